@@ hdl/npid_pkg.sv @@
package npid_pkg;

  localparam int PRIO_BITS = 15;
  localparam int CUR_BITS  = 16;
  localparam int ID_BITS   = 8;
  localparam int NEST_BITS = 5;
  localparam int KIND_BITS = 2;

  localparam logic [CUR_BITS-1:0] IDLE_PRIORITY = 16'h8000;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DONE = 1'b1
  } opcode_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_DROPPED  = 2'd1,
    KIND_NO_RUN   = 2'd2
  } kind_t;

endpackage

@@ hdl/nested_priority_irq_dispatcher_core.sv @@
// Nested priority interrupt dispatcher. Add transfers (tuser = 0) queue a handler id with
// its priority (lower is more urgent, ties keep arrival order); done transfers (tuser = 1)
// end the running handler and restore the priority it interrupted. After either, the queue
// head is dispatched if it is strictly more urgent than the current priority. The queue is
// a circular buffer in one RAM kept sorted by an insertion sweep that moves one entry per
// cycle from the tail; saved priorities live in a second RAM used as a stack. An add to a
// full queue skips the sweep and otherwise lasts as long as the sweep runs; adds and dones
// can also wait for the output register to free up. A result waits in the output register
// while the next input is taken.
module nested_priority_irq_dispatcher_core #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int NEST_DEPTH      = 16,
  parameter int HANDLER_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // priority_req[14:0], handler_id[22:15], zero fill
  input  logic [0:0]  s_tuser,   // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // dispatched_id[7:0], dispatched_priority[22:8],
                                 // nesting_level[27:23], zero fill
  output logic [1:0]  m_tuser    // kind[1:0]
);

  import npid_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(NEST_DEPTH);
  localparam int DW = $clog2(NEST_DEPTH + 1);
  localparam int EW = PRIO_BITS + HANDLER_ID_BITS;
  localparam logic [QW:0]   QD   = (QW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] QMAX = CW'(QUEUE_DEPTH);
  localparam logic [DW-1:0] NMAX = DW'(NEST_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS      = 7'b0000010,
    S_INS_FIN  = 7'b0000100,
    S_DISP_RD  = 7'b0001000,
    S_DISP_CHK = 7'b0010000,
    S_POP      = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t                     state, state_next;
  logic [CW-1:0]              count, count_next;
  logic [QW-1:0]              head, head_next;
  logic [QW-1:0]              idx, idx_next;
  logic [DW-1:0]              sdepth, sdepth_next;
  logic [CUR_BITS-1:0]        cur, cur_next;
  logic [PRIO_BITS-1:0]       req_prio, req_prio_next;
  logic [HANDLER_ID_BITS-1:0] req_id, req_id_next;
  kind_t                      res_kind, res_kind_next;
  logic [ID_BITS-1:0]         res_id, res_id_next;
  logic [PRIO_BITS-1:0]       res_prio, res_prio_next;
  logic [NEST_BITS-1:0]       res_nest, res_nest_next;
  logic                       m_tvalid_next;

  logic                       q_we;
  logic [QW-1:0]              q_waddr, q_raddr;
  logic [EW-1:0]              q_wdata, q_rdata;
  logic                       s_we;
  logic [SW-1:0]              s_waddr, s_raddr;
  logic [CUR_BITS-1:0]        s_wdata, s_rdata;

  logic [PRIO_BITS-1:0]       rd_prio;
  logic [HANDLER_ID_BITS-1:0] rd_id;
  logic                       out_free;
  logic                       in_xfer;
  opcode_t                    in_op;

  function automatic logic [QW-1:0] qaddr(input logic [QW-1:0] base, input logic [QW-1:0] ofs);
    logic [QW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= QD) begin
      sum = sum - QD;
    end
    return sum[QW-1:0];
  endfunction

  npid_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  npid_ram #(.WIDTH(CUR_BITS), .DEPTH(NEST_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign rd_prio  = q_rdata[PRIO_BITS-1:0];
  assign rd_id    = q_rdata[EW-1:PRIO_BITS];
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign in_op    = opcode_t'(s_tuser[0]);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    count_next    = count;
    head_next     = head;
    idx_next      = idx;
    sdepth_next   = sdepth;
    cur_next      = cur;
    req_prio_next = req_prio;
    req_id_next   = req_id;
    res_kind_next = res_kind;
    res_id_next   = res_id;
    res_prio_next = res_prio;
    res_nest_next = res_nest;
    q_we          = 1'b0;
    q_waddr       = head;
    q_wdata       = {req_id, req_prio};
    q_raddr       = head;
    s_we          = 1'b0;
    s_waddr       = sdepth[SW-1:0];
    s_wdata       = cur;
    s_raddr       = SW'(sdepth - DW'(1));
    m_tvalid_next = m_tvalid && !m_tready;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          req_prio_next = s_tdata[PRIO_BITS-1:0];
          req_id_next   = HANDLER_ID_BITS'(s_tdata[PRIO_BITS +: ID_BITS]);
          if (in_op == OP_ADD) begin
            if (count == QMAX) begin
              res_kind_next = KIND_DROPPED;
              res_id_next   = ID_BITS'(HANDLER_ID_BITS'(s_tdata[PRIO_BITS +: ID_BITS]));
              res_prio_next = s_tdata[PRIO_BITS-1:0];
              res_nest_next = NEST_BITS'(sdepth);
              state_next    = S_EMIT;
            end else if (count == '0) begin
              q_we       = 1'b1;
              q_waddr    = head;
              q_wdata    = {HANDLER_ID_BITS'(s_tdata[PRIO_BITS +: ID_BITS]),
                            s_tdata[PRIO_BITS-1:0]};
              count_next = count + CW'(1);
              state_next = S_DISP_RD;
            end else begin
              idx_next   = QW'(count - CW'(1));
              q_raddr    = qaddr(head, QW'(count - CW'(1)));
              state_next = S_INS;
            end
          end else begin
            if (sdepth == '0) begin
              res_kind_next = KIND_NO_RUN;
              res_id_next   = '0;
              res_prio_next = '0;
              res_nest_next = '0;
              state_next    = S_EMIT;
            end else begin
              sdepth_next = sdepth - DW'(1);
              state_next  = S_POP;
            end
          end
        end
      end
      S_INS: begin
        q_we    = 1'b1;
        q_waddr = qaddr(head, idx + QW'(1));
        if (rd_prio > req_prio) begin
          q_wdata = q_rdata;
          if (idx == '0) begin
            state_next = S_INS_FIN;
          end else begin
            idx_next = idx - QW'(1);
            q_raddr  = qaddr(head, idx - QW'(1));
          end
        end else begin
          count_next = count + CW'(1);
          state_next = S_DISP_RD;
        end
      end
      S_INS_FIN: begin
        q_we       = 1'b1;
        q_waddr    = head;
        count_next = count + CW'(1);
        state_next = S_DISP_RD;
      end
      S_POP: begin
        cur_next   = s_rdata;
        state_next = S_DISP_RD;
      end
      S_DISP_RD: begin
        if (count == '0 || sdepth == NMAX) begin
          state_next = S_IDLE;
        end else begin
          q_raddr    = head;
          state_next = S_DISP_CHK;
        end
      end
      S_DISP_CHK: begin
        if ({1'b0, rd_prio} < cur) begin
          s_we          = 1'b1;
          sdepth_next   = sdepth + DW'(1);
          cur_next      = {1'b0, rd_prio};
          head_next     = qaddr(head, QW'(1));
          count_next    = count - CW'(1);
          res_kind_next = KIND_DISPATCH;
          res_id_next   = ID_BITS'(rd_id);
          res_prio_next = rd_prio;
          res_nest_next = NEST_BITS'(sdepth + DW'(1));
          state_next    = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head     <= '0;
      sdepth   <= '0;
      cur      <= IDLE_PRIORITY;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      head     <= head_next;
      sdepth   <= sdepth_next;
      cur      <= cur_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    req_prio <= req_prio_next;
    req_id   <= req_id_next;
    res_kind <= res_kind_next;
    res_id   <= res_id_next;
    res_prio <= res_prio_next;
    res_nest <= res_nest_next;
    if (state == S_EMIT && out_free) begin
      m_tdata <= {4'b0, res_nest, res_prio, res_id};
      m_tuser <= res_kind;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= QMAX)
    else $error("queue count exceeds depth");

  a_nest_bound: assert property (@(posedge clk) disable iff (rst) sdepth <= NMAX)
    else $error("nesting depth exceeds stack size");

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    (state != S_POP) |-> ((sdepth == '0) == (cur == IDLE_PRIORITY)))
    else $error("current priority inconsistent with nesting depth");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !out_free) |=> (state == S_EMIT))
    else $error("result lost while output stalled");
`endif

endmodule

@@ hdl/npid_ram.sv @@
module npid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/nested_priority_irq_dispatcher_core_tb.sv @@
module nested_priority_irq_dispatcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npid_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int NDEPTH      = 16;
  localparam int MAX_GAP     = 18;
  localparam int DRAIN_WAIT  = QDEPTH + 16;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    kind_t             kind;
    logic [7:0]        id;
    logic [PRIO_BITS-1:0] prio;
    logic [NEST_BITS-1:0] nest;
  } irq_result_t;

  typedef enum int {
    PRIO_ANY,
    PRIO_CLUSTER,
    PRIO_DEEPER
  } prio_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  // dispatcher state mirror
  logic [PRIO_BITS-1:0] pq_prio [QDEPTH];
  logic [7:0]           pq_id   [QDEPTH];
  int                   pq_count;
  logic [CUR_BITS-1:0]  run_prio;
  logic [CUR_BITS-1:0]  saved_prio [NDEPTH];
  int                   run_depth;
  int                   deepest;

  irq_result_t pending_results [$];

  int  mismatches;
  int  n_sent;
  int  n_dispatch;
  int  n_dropped;
  int  n_no_run;
  int  cycles;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  bit  rx_hold = 1'b0;
  int  stall_left;
  int  rx_wait;

  nested_priority_irq_dispatcher_core #(
    .QUEUE_DEPTH    (QDEPTH),
    .NEST_DEPTH     (NDEPTH),
    .HANDLER_ID_BITS(ID_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void push_result(kind_t kind, logic [7:0] id, logic [PRIO_BITS-1:0] prio);
    irq_result_t r;
    r.kind = kind;
    r.id   = id;
    r.prio = prio;
    r.nest = run_depth[NEST_BITS-1:0];
    pending_results.push_back(r);
  endfunction

  function automatic void try_dispatch();
    logic [PRIO_BITS-1:0] head_prio;
    logic [7:0]           head_id;
    if (pq_count == 0 || run_depth >= NDEPTH) return;
    head_prio = pq_prio[0];
    head_id   = pq_id[0];
    if (!({1'b0, head_prio} < run_prio)) return;
    for (int i = 1; i < pq_count; i++) begin
      pq_prio[i-1] = pq_prio[i];
      pq_id[i-1]   = pq_id[i];
    end
    pq_count--;
    saved_prio[run_depth] = run_prio;
    run_depth++;
    if (run_depth > deepest) deepest = run_depth;
    run_prio = {1'b0, head_prio};
    push_result(KIND_DISPATCH, head_id, head_prio);
  endfunction

  function automatic void predict_dispatch(opcode_t op, logic [PRIO_BITS-1:0] p,
                                           logic [7:0] id);
    int pos;
    if (op == OP_ADD) begin
      if (pq_count >= QDEPTH) begin
        push_result(KIND_DROPPED, id, p);
        return;
      end
      pos = 0;
      while (pos < pq_count && pq_prio[pos] <= p) pos++;
      for (int i = pq_count; i > pos; i--) begin
        pq_prio[i] = pq_prio[i-1];
        pq_id[i]   = pq_id[i-1];
      end
      pq_prio[pos] = p;
      pq_id[pos]   = id;
      pq_count++;
      try_dispatch();
    end else begin
      if (run_depth == 0) begin
        push_result(KIND_NO_RUN, '0, '0);
        return;
      end
      run_depth--;
      run_prio = saved_prio[run_depth];
      try_dispatch();
    end
  endfunction

  task automatic send_item(input opcode_t op, input logic [PRIO_BITS-1:0] p,
                           input logic [7:0] id);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, id, p};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_dispatch(op, p, id);
    n_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic drain_to_idle();
    while (pq_count > 0 || run_depth > 0)
      send_item(OP_DONE, PRIO_BITS'($urandom), 8'($urandom));
  endtask

  task automatic send_random(input int add_pct, input prio_mode_t mode);
    opcode_t              op;
    logic [PRIO_BITS-1:0] p;
    logic [7:0]           id;
    int                   low;
    op = ($urandom_range(1, 100) <= add_pct) ? OP_ADD : OP_DONE;
    id = 8'($urandom_range(0, 255));
    case (mode)
      PRIO_ANY: p = PRIO_BITS'($urandom_range(0, 32767));
      PRIO_CLUSTER: begin
        case ($urandom_range(0, 3))
          0: p = '0;
          1: p = '1;
          default: p = PRIO_BITS'($urandom_range(0, 7));
        endcase
      end
      default: begin
        low = int'(run_prio) - int'($urandom_range(1, 64));
        p = (low < 0) ? '0 : PRIO_BITS'(low);
      end
    endcase
    send_item(op, p, id);
  endtask

  // idle done, equal priorities in arrival order, extreme values
  task automatic test_idle_and_ties();
    send_item(OP_DONE, '0, '0);
    send_item(OP_ADD, 15'h7FFF, 8'hFF);
    send_item(OP_ADD, 15'h7FFF, 8'h00);
    send_item(OP_ADD, 15'h7FFF, 8'h01);
    send_item(OP_DONE, '1, '1);
    send_item(OP_DONE, '0, '0);
    send_item(OP_DONE, '0, '0);
    send_item(OP_DONE, '0, '0);
    send_item(OP_ADD, 15'h0000, 8'h00);
    drain_to_idle();
  endtask

  task automatic test_queue_full();
    send_item(OP_ADD, 15'h0000, 8'h5A);
    for (int k = 0; k < QDEPTH; k++)
      send_item(OP_ADD, PRIO_BITS'($urandom_range(0, 3)), 8'(k * 17));
    send_item(OP_ADD, 15'h7FFF, 8'hFF);
    send_item(OP_ADD, 15'h0000, 8'h00);
    drain_to_idle();
  endtask

  task automatic test_nest_full();
    for (int k = NDEPTH; k >= 1; k--)
      send_item(OP_ADD, PRIO_BITS'(k), 8'(k));
    send_item(OP_ADD, 15'h0000, 8'hC3);
    send_item(OP_DONE, '0, '0);
    drain_to_idle();
  endtask

  task automatic test_output_backpressure();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    tx_idle_en = 1'b0;
    for (int k = 0; k < 60; k++) send_random(50, PRIO_ANY);
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_sender_pause();
    for (int k = 0; k < 30; k++) send_random(70, PRIO_DEEPER);
    wait_drained();
    for (int k = 0; k < 30; k++) send_random(40, PRIO_CLUSTER);
  endtask

  task automatic test_random(input int total);
    int         sent;
    int         add_pct;
    int         chunk;
    prio_mode_t mode;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(0, 3))
        0: add_pct = 25;
        1: add_pct = 50;
        2: add_pct = 75;
        default: add_pct = 90;
      endcase
      mode = prio_mode_t'($urandom_range(0, 2));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      chunk = $urandom_range(40, 120);
      for (int k = 0; k < chunk && sent < total; k++) begin
        send_random(add_pct, mode);
        sent++;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic check_result();
    irq_result_t e;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d id %0d", m_tuser, m_tdata[7:0]));
      return;
    end
    e = pending_results.pop_front();
    if (m_tuser !== e.kind)
      report_mismatch($sformatf("kind got %0d exp %0d", m_tuser, e.kind));
    if (m_tdata[7:0] !== e.id)
      report_mismatch($sformatf("id got %0d exp %0d", m_tdata[7:0], e.id));
    if (m_tdata[22:8] !== e.prio)
      report_mismatch($sformatf("priority got %0d exp %0d", m_tdata[22:8], e.prio));
    if (m_tdata[27:23] !== e.nest)
      report_mismatch($sformatf("nesting got %0d exp %0d", m_tdata[27:23], e.nest));
    case (e.kind)
      KIND_DISPATCH: n_dispatch++;
      KIND_DROPPED:  n_dropped++;
      default:       n_no_run++;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        rx_wait = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (rx_wait == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready   <= 1'b0;
          stall_left <= rx_wait;
        end
      end else if (!m_tready) begin
        if (stall_left > 1) begin
          stall_left <= stall_left - 1;
        end else begin
          m_tready   <= 1'b1;
          stall_left <= 0;
        end
      end
    end
  end

  initial begin
    pq_count  = 0;
    run_prio  = IDLE_PRIORITY;
    run_depth = 0;
    deepest   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_ties();
    test_queue_full();
    test_nest_full();
    test_output_backpressure();
    test_sender_pause();
    test_random(1000);

    s_tvalid <= 1'b0;
    for (int i = 0; i < 50000 && pending_results.size() > 0; i++) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d add/done transfers, checked %0d dispatches, %0d drops, %0d idle dones",
             n_sent, n_dispatch, n_dropped, n_no_run);
    $display("Deepest nesting reached %0d, mismatches %0d", deepest, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
